### rtl/core/ecq_pkg.sv
`timescale 1ns / 1ps

package ecq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;

    localparam logic [1:0] CMD_SAMPLE  = 2'd0;
    localparam logic [1:0] CMD_POP     = 2'd1;
    localparam logic [1:0] CMD_RESTART = 2'd2;
    localparam logic [1:0] CMD_NOP     = 2'd3;

    localparam logic [1:0] CLICK_NONE   = 2'd0;
    localparam logic [1:0] CLICK_SINGLE = 2'd1;
    localparam logic [1:0] CLICK_DOUBLE = 2'd2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_ID   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEP     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLICK_WINDOW = 2'd2;

    localparam logic [7:0]  CHANNEL_ID_RST   = 8'd0;
    localparam logic [14:0] MAX_STEP_RST     = 15'd64;
    localparam logic [15:0] CLICK_WINDOW_RST = 16'd300;

    typedef struct packed {
        logic [1:0]         command;
        logic signed [15:0] encoder_count;
        logic               button_pressed;
        logic               device_available;
        logic [31:0]        now_ms;
    } in_item_t;

    typedef struct packed {
        logic               event_valid;
        logic [7:0]         event_channel;
        logic signed [15:0] event_rotation;
        logic [1:0]         event_click;
        logic [31:0]        event_time_ms;
        logic [3:0]         queue_count;
        logic               dropped;
    } out_item_t;

    typedef struct packed {
        logic [7:0]         channel;
        logic signed [15:0] rotation;
        logic [1:0]         click;
        logic [31:0]        time_ms;
    } ring_entry_t;

    typedef struct packed {
        logic [7:0]  channel_id;
        logic [14:0] max_step;
        logic [15:0] click_window_ms;
    } cfg_t;

endpackage

### rtl/core/ecq_ring_mem.sv
`timescale 1ns / 1ps

module ecq_ring_mem
    import ecq_pkg::*;
#(
    parameter int DEPTH  = QUEUE_DEPTH_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  ring_entry_t       wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output ring_entry_t       rd_data
);

    ring_entry_t mem [DEPTH];
    ring_entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/core/ecq_event_ctrl.sv
`timescale 1ns / 1ps

module ecq_event_ctrl
    import ecq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  cfg_t      cfg,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_item,
    output logic      res_valid,
    input  logic      res_ready,
    output out_item_t res_item
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [PTR_W:0]   DEPTH_EXT = (PTR_W + 1)'(QUEUE_DEPTH);

    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
        return (p == LAST_IDX) ? '0 : p + 1'b1;
    endfunction

    logic signed [15:0] last_count_reg, last_count_next;
    logic               last_button_reg, last_button_next;
    logic               click_pending_reg, click_pending_next;
    logic [31:0]        pend_time_reg, pend_time_next;
    logic [PTR_W-1:0]   head_reg, head_next;
    logic [PTR_W-1:0]   tail_reg, tail_next;

    logic               wb_valid_reg, wb_valid_next;
    logic [PTR_W-1:0]   wb_addr_reg, wb_addr_next;
    ring_entry_t        wb_data_reg, wb_data_next;

    logic               r_valid_reg, r_valid_next;
    logic               r_ev_valid_reg, r_ev_valid_next;
    logic [3:0]         r_count_reg, r_count_next;
    logic               r_dropped_reg, r_dropped_next;

    logic               accept;
    logic signed [16:0] delta;
    logic signed [16:0] step_lim;
    logic               delta_ok;
    logic [31:0]        elapsed;
    logic               in_win;
    logic               rel;
    logic               rot_push;
    logic               click_push;
    logic               pop;
    logic               dropped;
    logic [PTR_W-1:0]   t1, t2, h1, h2;
    logic               drop1, drop2;
    logic [PTR_W:0]     diff;
    ring_entry_t        rot_entry;
    ring_entry_t        click_entry;

    logic               mem_we;
    logic [PTR_W-1:0]   mem_waddr;
    ring_entry_t        mem_wdata;
    ring_entry_t        mem_rdata;

    assign accept   = in_valid && in_ready;
    assign in_ready = !wb_valid_reg && (!r_valid_reg || res_ready);

    assign delta    = 17'(in_item.encoder_count) - 17'(last_count_reg);
    assign step_lim = signed'({2'b00, cfg.max_step});
    assign delta_ok = (delta <= step_lim) && (delta >= -step_lim);
    assign elapsed  = in_item.now_ms - pend_time_reg;
    assign in_win   = elapsed <= {16'd0, cfg.click_window_ms};
    assign rel      = in_item.device_available && last_button_reg && !in_item.button_pressed;

    assign t1    = ptr_next(tail_reg);
    assign drop1 = (t1 == head_reg);
    assign h1    = drop1 ? ptr_next(head_reg) : head_reg;
    assign t2    = ptr_next(t1);
    assign drop2 = (t2 == h1);
    assign h2    = drop2 ? ptr_next(h1) : h1;

    always_comb begin
        rot_entry.channel  = cfg.channel_id;
        rot_entry.rotation = delta[15:0];
        rot_entry.click    = CLICK_NONE;
        rot_entry.time_ms  = in_item.now_ms;

        click_entry.channel  = cfg.channel_id;
        click_entry.rotation = '0;
        click_entry.click    = (rel && in_win) ? CLICK_DOUBLE : CLICK_SINGLE;
        click_entry.time_ms  = (rel && in_win) ? in_item.now_ms : pend_time_reg;
    end

    always_comb begin
        last_count_next    = last_count_reg;
        last_button_next   = last_button_reg;
        click_pending_next = click_pending_reg;
        pend_time_next     = pend_time_reg;
        head_next          = head_reg;
        tail_next          = tail_reg;
        rot_push           = 1'b0;
        click_push         = 1'b0;
        pop                = 1'b0;
        dropped            = 1'b0;

        if (accept) begin
            unique case (in_item.command)
                CMD_SAMPLE: begin
                    if (in_item.device_available) begin
                        last_count_next  = in_item.encoder_count;
                        last_button_next = in_item.button_pressed;
                        if (delta_ok && (delta != '0)) begin
                            rot_push = 1'b1;
                        end
                    end
                    if (rel) begin
                        click_push         = click_pending_reg;
                        click_pending_next = !(click_pending_reg && in_win);
                        if (!(click_pending_reg && in_win)) begin
                            pend_time_next = in_item.now_ms;
                        end
                    end else if (click_pending_reg && !in_win) begin
                        click_push         = 1'b1;
                        click_pending_next = 1'b0;
                    end
                end
                CMD_POP: begin
                    if (head_reg != tail_reg) begin
                        pop       = 1'b1;
                        head_next = ptr_next(head_reg);
                    end
                end
                CMD_RESTART: begin
                    if (in_item.device_available) begin
                        last_count_next    = '0;
                        last_button_next   = in_item.button_pressed;
                        click_pending_next = 1'b0;
                        head_next          = '0;
                        tail_next          = '0;
                    end
                end
                CMD_NOP: begin
                end
            endcase

            if (rot_push && click_push) begin
                head_next = h2;
                tail_next = t2;
                dropped   = drop1 || drop2;
            end else if (rot_push || click_push) begin
                head_next = h1;
                tail_next = t1;
                dropped   = drop1;
            end
        end
    end

    always_comb begin
        wb_valid_next = 1'b0;
        wb_addr_next  = wb_addr_reg;
        wb_data_next  = wb_data_reg;
        if (accept && rot_push && click_push) begin
            wb_valid_next = 1'b1;
            wb_addr_next  = t1;
            wb_data_next  = click_entry;
        end

        if (wb_valid_reg) begin
            mem_we    = 1'b1;
            mem_waddr = wb_addr_reg;
            mem_wdata = wb_data_reg;
        end else begin
            mem_we    = accept && (rot_push || click_push);
            mem_waddr = tail_reg;
            mem_wdata = rot_push ? rot_entry : click_entry;
        end
    end

    always_comb begin
        if (tail_next >= head_next) begin
            diff = {1'b0, tail_next} - {1'b0, head_next};
        end else begin
            diff = {1'b0, tail_next} + DEPTH_EXT - {1'b0, head_next};
        end

        r_valid_next    = r_valid_reg && !res_ready;
        r_ev_valid_next = r_ev_valid_reg;
        r_count_next    = r_count_reg;
        r_dropped_next  = r_dropped_reg;
        if (accept) begin
            r_valid_next    = 1'b1;
            r_ev_valid_next = pop;
            r_count_next    = 4'(diff);
            r_dropped_next  = dropped;
        end
    end

    ecq_ring_mem #(
        .DEPTH  (QUEUE_DEPTH),
        .ADDR_W (PTR_W)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (accept && pop),
        .rd_addr (head_reg),
        .rd_data (mem_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_count_reg    <= '0;
            last_button_reg   <= 1'b0;
            click_pending_reg <= 1'b0;
            pend_time_reg     <= '0;
            head_reg          <= '0;
            tail_reg          <= '0;
            wb_valid_reg      <= 1'b0;
            r_valid_reg       <= 1'b0;
        end else begin
            last_count_reg    <= last_count_next;
            last_button_reg   <= last_button_next;
            click_pending_reg <= click_pending_next;
            pend_time_reg     <= pend_time_next;
            head_reg          <= head_next;
            tail_reg          <= tail_next;
            wb_valid_reg      <= wb_valid_next;
            r_valid_reg       <= r_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        wb_addr_reg    <= wb_addr_next;
        wb_data_reg    <= wb_data_next;
        r_ev_valid_reg <= r_ev_valid_next;
        r_count_reg    <= r_count_next;
        r_dropped_reg  <= r_dropped_next;
    end

    always_comb begin
        res_item.event_valid    = r_ev_valid_reg;
        res_item.event_channel  = r_ev_valid_reg ? mem_rdata.channel : '0;
        res_item.event_rotation = r_ev_valid_reg ? mem_rdata.rotation : '0;
        res_item.event_click    = r_ev_valid_reg ? mem_rdata.click : CLICK_NONE;
        res_item.event_time_ms  = r_ev_valid_reg ? mem_rdata.time_ms : '0;
        res_item.queue_count    = r_count_reg;
        res_item.dropped        = r_dropped_reg;
    end

    assign res_valid = r_valid_reg;

endmodule

### rtl/core/encoder_click_event_queue_unit.sv
`timescale 1ns / 1ps

// Encoder click and rotation event queue.
// The s_ channel carries one command item: a sample of the encoder count and
// button level, a pop of the oldest queued event, a restart, or a no-op.
// Every accepted item gives exactly one result item on the m_ channel, with
// the popped event (if any), the number of events held and a drop flag.
// The cfg_ channel writes the channel identifier, the step limit and the
// double-click window; it is always ready. It is to be written only while the
// block idles, which the user must ensure: the block does not enforce it.
// A result passes through the registered ring read and result stage, then
// the output register. One item is taken per cycle while the output is not
// stalled, except that a sample which queues two events holds the input off
// while the second event is written through the ring memory's single write port.
// Reset empties the ring, clears the pending click and restores the register
// defaults; the ring contents themselves are not cleared.
// When the receiver stalls, the output register and one internal result stage
// fill, after which s_ready drops until m_ready returns.
module encoder_click_event_queue_unit
    import ecq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t      cfg_reg;
    logic      res_valid;
    logic      res_ready;
    out_item_t res_item;
    logic      out_valid_reg, out_valid_next;
    out_item_t out_item_reg, out_item_next;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.channel_id      <= CHANNEL_ID_RST;
            cfg_reg.max_step        <= MAX_STEP_RST;
            cfg_reg.click_window_ms <= CLICK_WINDOW_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_CHANNEL_ID:   cfg_reg.channel_id      <= cfg_data[7:0];
                CFG_MAX_STEP:     cfg_reg.max_step        <= cfg_data[14:0];
                CFG_CLICK_WINDOW: cfg_reg.click_window_ms <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    ecq_event_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_item   (s_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_item  (res_item)
    );

    assign res_ready = !out_valid_reg || m_ready;

    always_comb begin
        out_valid_next = out_valid_reg && !m_ready;
        out_item_next  = out_item_reg;
        if (res_valid && res_ready) begin
            out_valid_next = 1'b1;
            out_item_next  = res_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_item_reg <= out_item_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_item_reg;

endmodule

### tb/encoder_click_event_queue_unit_tb.sv
`timescale 1ns / 1ps

module encoder_click_event_queue_unit_tb;
    import ecq_pkg::*;

    localparam int RING_SLOTS = QUEUE_DEPTH_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int ITEMS_PER_PHASE = 212;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;
    localparam out_item_t NO_EVENT = '0;

    typedef struct {
        in_item_t  item;
        bit        typed;
        out_item_t result;
    } stim_row_t;

    logic                  aclk;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    in_item_t              s_data = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    out_item_t             m_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Marks an item whose result was written into the table by hand.
    bit        held_typed = 1'b0;
    out_item_t held_result = '0;

    int send_idle_pct = 12;
    int recv_stall_pct = 45;
    int mismatches = 0;
    int cycle_count = 0;

    out_item_t event_reports_due[$];

    // Predicted state of the block.
    logic [7:0]         cfg_channel;
    logic [14:0]        cfg_max_step;
    logic [15:0]        cfg_window;
    logic signed [15:0] prv_count;
    logic               prv_button;
    logic               click_armed;
    logic [31:0]        release_time;
    ring_entry_t        ring_mem [RING_SLOTS];
    logic [3:0]         rd_ptr;
    logic [3:0]         wr_ptr;
    logic               step_overwrote;

    // Stimulus shaping state: a plausible encoder and button over time.
    logic [31:0]        gen_time = 32'h20;
    logic signed [15:0] gen_count = '0;
    logic               gen_button = 1'b0;

    stim_row_t directed_rows [25] = '{
        '{'{CMD_POP, 16'sh7FFF, 1'b1, 1'b1, 32'hFFFF_FFFF}, 1'b1, NO_EVENT},
        '{'{CMD_NOP, 16'sh8000, 1'b0, 1'b0, 32'd0}, 1'b1, NO_EVENT},
        '{'{CMD_SAMPLE, 16'sd64, 1'b0, 1'b1, 32'd100}, 1'b1,
          '{1'b0, 8'd0, 16'sd0, CLICK_NONE, 32'd0, 4'd1, 1'b0}},
        '{'{CMD_POP, 16'sd0, 1'b0, 1'b1, 32'd105}, 1'b1,
          '{1'b1, 8'd0, 16'sd64, CLICK_NONE, 32'd100, 4'd0, 1'b0}},
        '{'{CMD_SAMPLE, 16'shFFFF, 1'b0, 1'b1, 32'd110}, 1'b1, NO_EVENT},
        '{'{CMD_SAMPLE, 16'shFFBF, 1'b0, 1'b1, 32'd120}, 1'b0, NO_EVENT},
        '{'{CMD_SAMPLE, 16'sh7FFF, 1'b1, 1'b0, 32'd130}, 1'b0, NO_EVENT},
        '{'{CMD_SAMPLE, 16'sh8000, 1'b0, 1'b1, 32'd140}, 1'b0, NO_EVENT},
        '{'{CMD_SAMPLE, 16'sh8000, 1'b1, 1'b1, 32'd200}, 1'b0, NO_EVENT},
        '{'{CMD_SAMPLE, 16'sh8000, 1'b0, 1'b1, 32'd250}, 1'b0, NO_EVENT},
        '{'{CMD_SAMPLE, 16'sh8000, 1'b1, 1'b1, 32'd300}, 1'b0, NO_EVENT},
        '{'{CMD_SAMPLE, 16'sh8000, 1'b0, 1'b1, 32'd550}, 1'b0, NO_EVENT},
        '{'{CMD_SAMPLE, 16'sh8000, 1'b1, 1'b1, 32'd600}, 1'b0, NO_EVENT},
        '{'{CMD_SAMPLE, 16'sh8000, 1'b0, 1'b1, 32'd700}, 1'b0, NO_EVENT},
        '{'{CMD_SAMPLE, 16'sh8000, 1'b0, 1'b0, 32'd1001}, 1'b0, NO_EVENT},
        '{'{CMD_SAMPLE, 16'sh8000, 1'b1, 1'b1, 32'd1100}, 1'b0, NO_EVENT},
        '{'{CMD_SAMPLE, 16'sh8000, 1'b0, 1'b1, 32'd1200}, 1'b0, NO_EVENT},
        '{'{CMD_SAMPLE, 16'sh8000, 1'b1, 1'b1, 32'd1300}, 1'b0, NO_EVENT},
        '{'{CMD_SAMPLE, 16'sh8000, 1'b0, 1'b1, 32'd1600}, 1'b0, NO_EVENT},
        '{'{CMD_RESTART, 16'sh1234, 1'b1, 1'b0, 32'd1650}, 1'b0, NO_EVENT},
        '{'{CMD_RESTART, 16'sh4321, 1'b1, 1'b1, 32'd1700}, 1'b1, NO_EVENT},
        '{'{CMD_SAMPLE, 16'sd0, 1'b0, 1'b1, 32'hFFFF_FF00}, 1'b0, NO_EVENT},
        '{'{CMD_SAMPLE, 16'sd0, 1'b1, 1'b1, 32'h0000_0010}, 1'b0, NO_EVENT},
        '{'{CMD_SAMPLE, 16'sd0, 1'b0, 1'b1, 32'h0000_0020}, 1'b0, NO_EVENT},
        '{'{CMD_POP, 16'sd0, 1'b0, 1'b0, 32'h0000_0030}, 1'b1,
          '{1'b1, 8'd0, 16'sd0, CLICK_DOUBLE, 32'h0000_0020, 4'd0, 1'b0}}
    };

    encoder_click_event_queue_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    function automatic void ring_store(logic signed [15:0] rot, logic [1:0] kind,
                                       logic [31:0] stamp);
        logic [3:0] nxt;
        nxt = wr_ptr + 4'd1;
        if (nxt == rd_ptr) begin
            rd_ptr = rd_ptr + 4'd1;
            step_overwrote = 1'b1;
        end
        ring_mem[wr_ptr] = '{channel: cfg_channel, rotation: rot, click: kind, time_ms: stamp};
        wr_ptr = nxt;
    endfunction

    function automatic out_item_t step_event_queue(in_item_t it);
        out_item_t res;
        int delta;
        int lim;
        res = '0;
        step_overwrote = 1'b0;
        lim = cfg_max_step;
        case (it.command)
            CMD_SAMPLE: begin
                if (it.device_available) begin
                    delta = int'($signed(it.encoder_count)) - int'($signed(prv_count));
                    if (delta > lim || delta < -lim) begin
                        delta = 0;
                    end
                    prv_count = it.encoder_count;
                    if (delta != 0) begin
                        ring_store(delta[15:0], CLICK_NONE, it.now_ms);
                    end
                    if (it.button_pressed != prv_button) begin
                        if (!it.button_pressed) begin
                            if (click_armed &&
                                    (it.now_ms - release_time) <= {16'd0, cfg_window}) begin
                                click_armed = 1'b0;
                                ring_store(16'sd0, CLICK_DOUBLE, it.now_ms);
                            end else begin
                                if (click_armed) begin
                                    ring_store(16'sd0, CLICK_SINGLE, release_time);
                                end
                                click_armed = 1'b1;
                                release_time = it.now_ms;
                            end
                        end
                        prv_button = it.button_pressed;
                    end
                end
                if (click_armed && (it.now_ms - release_time) > {16'd0, cfg_window}) begin
                    ring_store(16'sd0, CLICK_SINGLE, release_time);
                    click_armed = 1'b0;
                end
            end
            CMD_POP: begin
                if (rd_ptr != wr_ptr) begin
                    res.event_valid = 1'b1;
                    res.event_channel = ring_mem[rd_ptr].channel;
                    res.event_rotation = ring_mem[rd_ptr].rotation;
                    res.event_click = ring_mem[rd_ptr].click;
                    res.event_time_ms = ring_mem[rd_ptr].time_ms;
                    rd_ptr = rd_ptr + 4'd1;
                end
            end
            CMD_RESTART: begin
                if (it.device_available) begin
                    prv_count = '0;
                    prv_button = it.button_pressed;
                    click_armed = 1'b0;
                    rd_ptr = '0;
                    wr_ptr = '0;
                end
            end
            default: begin
            end
        endcase
        res.queue_count = wr_ptr - rd_ptr;
        res.dropped = step_overwrote;
        return res;
    endfunction

    task automatic report_field(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %h, got %h", $time, field, want, got);
        end
    endtask

    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            cfg_channel = CHANNEL_ID_RST;
            cfg_max_step = MAX_STEP_RST;
            cfg_window = CLICK_WINDOW_RST;
            prv_count = '0;
            prv_button = 1'b0;
            click_armed = 1'b0;
            release_time = '0;
            rd_ptr = '0;
            wr_ptr = '0;
            event_reports_due.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (event_reports_due.size() == 0) begin
                    $display("%0t: unexpected result: expected none, got %h", $time, m_data);
                    mismatches++;
                end else begin
                    want = event_reports_due.pop_front();
                    if (m_data !== want) begin
                        report_field("event_valid", want.event_valid, m_data.event_valid);
                        report_field("event_channel", want.event_channel, m_data.event_channel);
                        report_field("event_rotation", want.event_rotation,
                                     m_data.event_rotation);
                        report_field("event_click", want.event_click, m_data.event_click);
                        report_field("event_time_ms", want.event_time_ms, m_data.event_time_ms);
                        report_field("queue_count", want.queue_count, m_data.queue_count);
                        report_field("dropped", want.dropped, m_data.dropped);
                        mismatches++;
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_CHANNEL_ID:   cfg_channel = cfg_data[7:0];
                    CFG_MAX_STEP:     cfg_max_step = cfg_data[14:0];
                    CFG_CLICK_WINDOW: cfg_window = cfg_data;
                    default: begin
                    end
                endcase
            end
            if (s_valid && s_ready) begin
                want = step_event_queue(s_data);
                event_reports_due.push_back(held_typed ? held_result : want);
            end
        end
    end

    function automatic in_item_t next_stimulus(int step_lim, int window, int pop_pct);
        in_item_t it;
        int roll;
        int d;
        it.command = CMD_SAMPLE;
        it.encoder_count = 16'($urandom());
        it.button_pressed = 1'($urandom());
        it.device_available = 1'($urandom());
        it.now_ms = $urandom();
        d = 0;
        roll = $urandom_range(0, 99);
        if (roll < 8) begin
            it.command = 2'($urandom());
        end else if (roll < 8 + pop_pct) begin
            it.command = CMD_POP;
        end else if (roll < 11 + pop_pct) begin
            it.command = CMD_RESTART;
            it.device_available = ($urandom_range(0, 3) != 0);
            if (it.device_available) begin
                gen_count = '0;
                gen_button = it.button_pressed;
            end
        end else if (roll < 13 + pop_pct) begin
            it.command = CMD_NOP;
        end else begin
            gen_time = gen_time + $urandom_range(0, 2 * window + 4);
            it.now_ms = gen_time;
            it.device_available = ($urandom_range(0, 9) != 0);
            roll = $urandom_range(0, 9);
            if (roll < 5) begin
                d = int'($urandom_range(0, 2 * step_lim + 4)) - (step_lim + 2);
            end else if (roll == 8) begin
                d = step_lim + int'($urandom_range(0, 1));
                if ($urandom_range(0, 1) != 0) begin
                    d = -d;
                end
            end
            if (roll < 9) begin
                it.encoder_count = gen_count + 16'(d);
            end
            it.button_pressed = ($urandom_range(0, 99) < 35) ? !gen_button : gen_button;
            if (it.device_available) begin
                gen_count = it.encoder_count;
                gen_button = it.button_pressed;
            end
        end
        return it;
    endfunction

    task automatic hold_off_sender();
        while ($urandom_range(0, 99) < send_idle_pct) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
    endtask

    task automatic offer_item(in_item_t item, bit typed, out_item_t result);
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data <= item;
        held_typed <= typed;
        held_result <= result;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic settle_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (event_reports_due.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic program_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        in_item_t item;
        logic [15:0] ph_channel;
        logic [15:0] ph_step;
        logic [15:0] ph_window;
        int step_lim;
        int window;
        int pop_pct;
        pop_pct = 20;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            hold_off_sender();
            offer_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].result);
        end

        for (int phase = 0; phase < 6; phase++) begin
            settle_results();
            case (phase)
                0: begin
                    ph_channel = 16'h005A;
                    ph_step = 16'd100;
                    ph_window = 16'd300;
                end
                1: begin
                    ph_channel = 16'hFFFF;
                    ph_step = 16'hFFFF;
                    ph_window = 16'hFFFF;
                end
                2: begin
                    ph_channel = 16'h0000;
                    ph_step = 16'd0;
                    ph_window = 16'd0;
                end
                3: begin
                    ph_channel = 16'h013C;
                    ph_step = 16'd1;
                    ph_window = 16'd1;
                end
                4: begin
                    ph_channel = 16'($urandom());
                    ph_step = 16'($urandom_range(1, 500));
                    ph_window = 16'($urandom_range(50, 1000));
                end
                default: begin
                    ph_channel = 16'($urandom());
                    ph_step = 16'd200;
                    ph_window = 16'd250;
                end
            endcase
            program_register(CFG_CHANNEL_ID, ph_channel);
            program_register(CFG_MAX_STEP, ph_step);
            program_register(CFG_CLICK_WINDOW, ph_window);
            if (phase == 3) begin
                program_register(CFG_UNUSED_IDX, 16'($urandom()));
            end
            step_lim = int'(ph_step[14:0]);
            window = int'(ph_window);
            case (phase % 3)
                0: begin
                    send_idle_pct = 12;
                    recv_stall_pct = 45;
                end
                1: begin
                    send_idle_pct = 45;
                    recv_stall_pct = 12;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (n % 40 == 0) begin
                    pop_pct = $urandom_range(5, 45);
                end
                item = next_stimulus(step_lim, window, pop_pct);
                hold_off_sender();
                offer_item(item, 1'b0, NO_EVENT);
            end
        end

        settle_results();
        repeat (10) @(posedge aclk);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
